// File: rtl/core/cexp_pkg.sv
// ----------------------------------------------------------------------------
// cexp_pkg
// shared codes, decoded-instruction struct and encoder formats for the
// compressed instruction expander
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cexp_pkg;

	// widths
	localparam int unsigned CWORD_W = 16;
	localparam int unsigned XWORD_W = 32;
	localparam int unsigned IMM_W   = 21;

	// quadrants
	localparam logic [1:0] QUAD_C0 = 2'd0;
	localparam logic [1:0] QUAD_C1 = 2'd1;
	localparam logic [1:0] QUAD_C2 = 2'd2;
	localparam logic [1:0] QUAD_NC = 2'd3;

	// compressed funct3, quadrant 0
	localparam logic [2:0] C0_ADDI4SPN = 3'd0;
	localparam logic [2:0] C0_LW       = 3'd2;
	localparam logic [2:0] C0_SW       = 3'd6;

	// compressed funct3, quadrant 1
	localparam logic [2:0] C1_ADDI  = 3'd0;
	localparam logic [2:0] C1_JAL   = 3'd1;
	localparam logic [2:0] C1_LI    = 3'd2;
	localparam logic [2:0] C1_LUI   = 3'd3;
	localparam logic [2:0] C1_ARITH = 3'd4;
	localparam logic [2:0] C1_J     = 3'd5;
	localparam logic [2:0] C1_BEQZ  = 3'd6;
	localparam logic [2:0] C1_BNEZ  = 3'd7;

	// arithmetic group selector, bits 11:10
	localparam logic [1:0] AR_SRLI = 2'd0;
	localparam logic [1:0] AR_SRAI = 2'd1;
	localparam logic [1:0] AR_ANDI = 2'd2;
	localparam logic [1:0] AR_REG  = 2'd3;

	// register-register group selector, bits 6:5
	localparam logic [1:0] RR_SUB = 2'd0;
	localparam logic [1:0] RR_XOR = 2'd1;
	localparam logic [1:0] RR_OR  = 2'd2;
	localparam logic [1:0] RR_AND = 2'd3;

	// compressed funct3, quadrant 2
	localparam logic [2:0] C2_SLLI = 3'd0;
	localparam logic [2:0] C2_LWSP = 3'd2;
	localparam logic [2:0] C2_JR   = 3'd4;
	localparam logic [2:0] C2_SWSP = 3'd6;

	// base opcodes
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_OPIMM  = 7'h13;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_JAL    = 7'h6F;

	// base funct3
	localparam logic [2:0] F3_ADD = 3'd0;
	localparam logic [2:0] F3_SLL = 3'd1;
	localparam logic [2:0] F3_W   = 3'd2;
	localparam logic [2:0] F3_XOR = 3'd4;
	localparam logic [2:0] F3_SR  = 3'd5;
	localparam logic [2:0] F3_OR  = 3'd6;
	localparam logic [2:0] F3_AND = 3'd7;
	localparam logic [2:0] F3_BEQ = 3'd0;
	localparam logic [2:0] F3_BNE = 3'd1;

	// base funct7
	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;

	// fixed registers
	localparam logic [4:0] REG_ZERO = 5'd0;
	localparam logic [4:0] REG_RA   = 5'd1;
	localparam logic [4:0] REG_SP   = 5'd2;

	typedef enum logic [2:0] {
		FMT_ILL,
		FMT_I,
		FMT_S,
		FMT_R,
		FMT_J,
		FMT_B,
		FMT_U
	} fmt_t;

	typedef struct packed {
		fmt_t             fmt;
		logic [6:0]       opc;
		logic [2:0]       f3;
		logic [6:0]       f7;
		logic [4:0]       rd;
		logic [4:0]       rs1;
		logic [4:0]       rs2;
		logic [IMM_W-1:0] imm;
	} dec_t;

endpackage

`default_nettype wire

// File: rtl/core/cexp_in_if.sv
// ----------------------------------------------------------------------------
// cexp_in_if
// request channel carrying one compressed halfword
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cexp_in_if
	import cexp_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [CWORD_W-1:0] compressed_word;

	modport source (output valid, output compressed_word, input ready);
	modport sink (input valid, input compressed_word, output ready);
endinterface

`default_nettype wire

// File: rtl/core/cexp_out_if.sv
// ----------------------------------------------------------------------------
// cexp_out_if
// request channel carrying one expanded instruction and its illegal flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cexp_out_if
	import cexp_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [XWORD_W-1:0] expanded_word;
	logic               illegal;

	modport source (output valid, output expanded_word, output illegal, input ready);
	modport sink (input valid, input expanded_word, input illegal, output ready);
endinterface

`default_nettype wire

// File: rtl/core/rvc_instruction_expander_top.sv
// ----------------------------------------------------------------------------
// rvc_instruction_expander_top
// path: capture, decode and output registers in order from an accepted request to its result on issue
// throughput: one halfword per cycle while issue does not stall; three pipeline stages, one request each
// reset: arst_n clears the stage valid bits, the pipeline comes up empty
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rvc_instruction_expander_top
	import cexp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	cexp_in_if.sink    fetch,
	cexp_out_if.source issue
);

	// stage 1: captured halfword
	// stage 2: decoded format and operands
	// stage 3: assembled word, also the output register
	logic               valid_s1;
	logic               valid_s2;
	logic               valid_s3;
	logic               ready_s1;
	logic               ready_s2;
	logic               ready_s3;
	logic [CWORD_W-1:0] word_s1;
	dec_t               dec_s2;
	logic [XWORD_W-1:0] xword_s3;
	logic               bad_s3;

	dec_t               dec_d;
	logic [XWORD_W-1:0] xword_d;
	logic               bad_d;

	// a stage takes a new request when empty or when its content moves on
	assign ready_s3    = !valid_s3 || issue.ready;
	assign ready_s2    = !valid_s2 || ready_s3;
	assign ready_s1    = !valid_s1 || ready_s2;
	assign fetch.ready = ready_s1;

	// field extraction and classification, between stage 1 and stage 2
	cexp_decode u_decode (
		.cword (word_s1),
		.dec   (dec_d)
	);

	// word assembly, between stage 2 and stage 3
	cexp_encode u_encode (
		.dec   (dec_s2),
		.xword (xword_d),
		.bad   (bad_d)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= fetch.valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	// payload, loaded only when a request enters the stage
	always_ff @(posedge clk) begin
		if (ready_s1 && fetch.valid) word_s1 <= fetch.compressed_word;
		if (ready_s2 && valid_s1) dec_s2 <= dec_d;
		if (ready_s3 && valid_s2) begin
			xword_s3 <= xword_d;
			bad_s3   <= bad_d;
		end
	end

	assign issue.valid         = valid_s3;
	assign issue.expanded_word = xword_s3;
	assign issue.illegal       = bad_s3;

	// an illegal result carries an all-zero word
	a_illegal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		issue.valid && issue.illegal |-> issue.expanded_word == '0)
		else $error("illegal result with nonzero word");

	// a legal result is always a full-length base instruction
	a_legal_full: assert property (@(posedge clk) disable iff (!arst_n)
		issue.valid && !issue.illegal |-> issue.expanded_word[1:0] == QUAD_NC)
		else $error("legal result without 32-bit opcode");

	// the all-zero halfword decodes to the illegal format
	a_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ready_s2 && word_s1 == '0 |=> valid_s2 && dec_s2.fmt == FMT_ILL)
		else $error("zero halfword not flagged");

	// a stalled output stage keeps its request
	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !issue.ready |=> valid_s3 && $stable(xword_s3) && $stable(bad_s3))
		else $error("output stage lost its request under stall");

endmodule

`default_nettype wire

// File: rtl/core/cexp_decode.sv
// ----------------------------------------------------------------------------
// cexp_decode
// classifies a compressed halfword and extracts base-format operands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cexp_decode
	import cexp_pkg::*;
(
	input  wire logic [CWORD_W-1:0] cword,
	output dec_t                    dec
);

	logic [1:0]       quad;
	logic [2:0]       f3c;
	logic             b12;
	logic [4:0]       rdf;
	logic [4:0]       rs2f;
	logic [4:0]       rlo;
	logic [4:0]       rhi;
	logic [IMM_W-1:0] imm_ci;
	logic [IMM_W-1:0] imm_cl;
	logic [IMM_W-1:0] imm_4spn;
	logic [IMM_W-1:0] imm_cj;
	logic [IMM_W-1:0] imm_cb;
	logic [IMM_W-1:0] imm_16sp;
	logic [IMM_W-1:0] imm_lwsp;
	logic [IMM_W-1:0] imm_swsp;
	logic [2:0]       rr_f3;

	assign quad = cword[1:0];
	assign f3c  = cword[15:13];
	assign b12  = cword[12];
	assign rdf  = cword[11:7];
	assign rs2f = cword[6:2];
	assign rlo  = {2'b01, cword[4:2]};
	assign rhi  = {2'b01, cword[9:7]};

	assign imm_ci   = {{15{cword[12]}}, cword[12], cword[6:2]};
	assign imm_cl   = {14'd0, cword[5], cword[12:10], cword[6], 2'd0};
	assign imm_4spn = {11'd0, cword[10:7], cword[12:11], cword[6], cword[5], 2'd0};
	assign imm_cj   = {{9{cword[12]}}, cword[12], cword[8], cword[10:9], cword[6],
		cword[7], cword[2], cword[11], cword[5:3], 1'b0};
	assign imm_cb   = {{12{cword[12]}}, cword[12], cword[6:5], cword[2], cword[11:10],
		cword[4:3], 1'b0};
	assign imm_16sp = {{11{cword[12]}}, cword[12], cword[4:3], cword[5], cword[2],
		cword[6], 4'd0};
	assign imm_lwsp = {13'd0, cword[3:2], cword[12], cword[6:4], 2'd0};
	assign imm_swsp = {13'd0, cword[8:7], cword[12:9], 2'd0};

	// sub, xor, or, and
	always_comb begin
		unique case (cword[6:5])
			RR_SUB:  rr_f3 = F3_ADD;
			RR_XOR:  rr_f3 = F3_XOR;
			RR_OR:   rr_f3 = F3_OR;
			RR_AND:  rr_f3 = F3_AND;
			default: rr_f3 = F3_ADD;
		endcase
	end

	always_comb begin
		dec     = '0;
		dec.fmt = FMT_ILL;
		unique case (quad)
			QUAD_C0: begin
				if (cword != '0) begin
					unique case (f3c)
						C0_ADDI4SPN: begin
							dec.fmt = FMT_I; dec.opc = OPC_OPIMM; dec.f3 = F3_ADD;
							dec.rd = rlo; dec.rs1 = REG_SP; dec.imm = imm_4spn;
						end
						C0_LW: begin
							dec.fmt = FMT_I; dec.opc = OPC_LOAD; dec.f3 = F3_W;
							dec.rd = rlo; dec.rs1 = rhi; dec.imm = imm_cl;
						end
						C0_SW: begin
							dec.fmt = FMT_S; dec.opc = OPC_STORE; dec.f3 = F3_W;
							dec.rs1 = rhi; dec.rs2 = rlo; dec.imm = imm_cl;
						end
						default: dec.fmt = FMT_ILL;
					endcase
				end
			end
			QUAD_C1: begin
				unique case (f3c)
					C1_ADDI: begin
						dec.fmt = FMT_I; dec.opc = OPC_OPIMM; dec.f3 = F3_ADD;
						dec.rd = rdf; dec.rs1 = rdf; dec.imm = imm_ci;
					end
					C1_JAL: begin
						dec.fmt = FMT_J; dec.opc = OPC_JAL; dec.rd = REG_RA; dec.imm = imm_cj;
					end
					C1_LI: begin
						dec.fmt = FMT_I; dec.opc = OPC_OPIMM; dec.f3 = F3_ADD;
						dec.rd = rdf; dec.rs1 = REG_ZERO; dec.imm = imm_ci;
					end
					C1_LUI: begin
						if (rdf == REG_SP) begin
							if (imm_16sp != '0) begin
								dec.fmt = FMT_I; dec.opc = OPC_OPIMM; dec.f3 = F3_ADD;
								dec.rd = REG_SP; dec.rs1 = REG_SP; dec.imm = imm_16sp;
							end
						end else if (rdf != REG_ZERO && {b12, rs2f} != '0) begin
							dec.fmt = FMT_U; dec.opc = OPC_LUI; dec.rd = rdf; dec.imm = imm_ci;
						end
					end
					C1_ARITH: begin
						unique case (cword[11:10])
							AR_SRLI, AR_SRAI: begin
								dec.fmt = FMT_R; dec.opc = OPC_OPIMM; dec.f3 = F3_SR;
								dec.rd = rhi; dec.rs1 = rhi; dec.rs2 = rs2f;
								dec.f7 = (cword[11:10] == AR_SRAI) ? F7_ALT : F7_BASE;
							end
							AR_ANDI: begin
								dec.fmt = FMT_I; dec.opc = OPC_OPIMM; dec.f3 = F3_AND;
								dec.rd = rhi; dec.rs1 = rhi; dec.imm = imm_ci;
							end
							AR_REG: begin
								if (!b12) begin
									dec.fmt = FMT_R; dec.opc = OPC_OP; dec.f3 = rr_f3;
									dec.rd = rhi; dec.rs1 = rhi; dec.rs2 = rlo;
									dec.f7 = (cword[6:5] == RR_SUB) ? F7_ALT : F7_BASE;
								end
							end
							default: dec.fmt = FMT_ILL;
						endcase
					end
					C1_J: begin
						dec.fmt = FMT_J; dec.opc = OPC_JAL; dec.rd = REG_ZERO; dec.imm = imm_cj;
					end
					C1_BEQZ, C1_BNEZ: begin
						dec.fmt = FMT_B; dec.opc = OPC_BRANCH; dec.rs1 = rhi;
						dec.rs2 = REG_ZERO; dec.imm = imm_cb;
						dec.f3 = (f3c == C1_BNEZ) ? F3_BNE : F3_BEQ;
					end
					default: dec.fmt = FMT_ILL;
				endcase
			end
			QUAD_C2: begin
				unique case (f3c)
					C2_SLLI: begin
						dec.fmt = FMT_R; dec.opc = OPC_OPIMM; dec.f3 = F3_SLL;
						dec.rd = rdf; dec.rs1 = rdf; dec.rs2 = rs2f; dec.f7 = F7_BASE;
					end
					C2_LWSP: begin
						if (rdf != REG_ZERO) begin
							dec.fmt = FMT_I; dec.opc = OPC_LOAD; dec.f3 = F3_W;
							dec.rd = rdf; dec.rs1 = REG_SP; dec.imm = imm_lwsp;
						end
					end
					C2_JR: begin
						if (rs2f == REG_ZERO) begin
							// jr / jalr
							if (rdf != REG_ZERO) begin
								dec.fmt = FMT_I; dec.opc = OPC_JALR; dec.f3 = F3_ADD;
								dec.rd = b12 ? REG_RA : REG_ZERO; dec.rs1 = rdf;
							end
						end else if (!b12 || rdf != REG_ZERO) begin
							// mv / add
							dec.fmt = FMT_R; dec.opc = OPC_OP; dec.f3 = F3_ADD;
							dec.rd = rdf; dec.rs1 = b12 ? rdf : REG_ZERO;
							dec.rs2 = rs2f; dec.f7 = F7_BASE;
						end
					end
					C2_SWSP: begin
						dec.fmt = FMT_S; dec.opc = OPC_STORE; dec.f3 = F3_W;
						dec.rs1 = REG_SP; dec.rs2 = rs2f; dec.imm = imm_swsp;
					end
					default: dec.fmt = FMT_ILL;
				endcase
			end
			QUAD_NC: dec.fmt = FMT_ILL;
			default: dec.fmt = FMT_ILL;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/core/cexp_encode.sv
// ----------------------------------------------------------------------------
// cexp_encode
// packs decoded operands into a 32-bit base instruction word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cexp_encode
	import cexp_pkg::*;
(
	input  dec_t                    dec,
	output logic [XWORD_W-1:0]      xword,
	output logic                    bad
);

	always_comb begin
		bad = 1'b0;
		unique case (dec.fmt)
			FMT_I: xword = {dec.imm[11:0], dec.rs1, dec.f3, dec.rd, dec.opc};
			FMT_S: xword = {dec.imm[11:5], dec.rs2, dec.rs1, dec.f3, dec.imm[4:0], dec.opc};
			FMT_R: xword = {dec.f7, dec.rs2, dec.rs1, dec.f3, dec.rd, dec.opc};
			FMT_J: xword = {dec.imm[20], dec.imm[10:1], dec.imm[11], dec.imm[19:12],
				dec.rd, dec.opc};
			FMT_B: xword = {dec.imm[12], dec.imm[10:5], dec.rs2, dec.rs1, dec.f3,
				dec.imm[4:1], dec.imm[11], dec.opc};
			FMT_U: xword = {dec.imm[19:0], dec.rd, dec.opc};
			default: begin
				xword = '0;
				bad   = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: sim/rvc_expansion_checker.sv
// ----------------------------------------------------------------------------
// rvc_expansion_checker
// watches the fetch and issue channels, predicts the 32-bit expansion of
// every accepted halfword and compares each issued result in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rvc_expansion_checker
	import cexp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fetch_valid,
	input  logic               fetch_ready,
	input  logic [CWORD_W-1:0] compressed_word,
	input  logic               issue_valid,
	input  logic               issue_ready,
	input  logic [XWORD_W-1:0] expanded_word,
	input  logic               illegal,
	output int                 failures,
	output int                 pending,
	output int                 results,
	output int                 illegal_results
);

	typedef struct packed {
		logic [XWORD_W-1:0] word;
		logic               ill;
	} expansion_t;

	expansion_t expected_expansions [$];

	function automatic logic [XWORD_W-1:0] enc_i(input logic [6:0] opc, input logic [2:0] f3,
			input logic [4:0] rd, input logic [4:0] rs1, input logic [11:0] imm);
		return {imm, rs1, f3, rd, opc};
	endfunction

	function automatic logic [XWORD_W-1:0] enc_s(input logic [2:0] f3, input logic [4:0] rs1,
			input logic [4:0] rs2, input logic [11:0] imm);
		return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
	endfunction

	function automatic logic [XWORD_W-1:0] enc_r(input logic [6:0] opc, input logic [2:0] f3,
			input logic [4:0] rd, input logic [4:0] rs1, input logic [4:0] rs2,
			input logic [6:0] f7);
		return {f7, rs2, rs1, f3, rd, opc};
	endfunction

	function automatic logic [XWORD_W-1:0] enc_j(input logic [4:0] rd, input logic [20:0] imm);
		return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
	endfunction

	function automatic logic [XWORD_W-1:0] enc_b(input logic [2:0] f3, input logic [4:0] rs1,
			input logic [12:0] imm);
		return {imm[12], imm[10:5], REG_ZERO, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
	endfunction

	function automatic expansion_t expand_halfword(input logic [CWORD_W-1:0] c);
		logic [4:0]         rd_full;
		logic [4:0]         rs2_full;
		logic [4:0]         rd_lo;
		logic [4:0]         rd_hi;
		logic [11:0]        imm_ci;
		logic [19:0]        imm_lui;
		logic [11:0]        imm_cl;
		logic [20:0]        imm_cj;
		logic [12:0]        imm_cb;
		logic [9:0]         imm_sp16;
		logic [XWORD_W-1:0] word;
		logic               ok;
		expansion_t         r;
		rd_full  = c[11:7];
		rs2_full = c[6:2];
		rd_lo    = {2'b01, c[4:2]};
		rd_hi    = {2'b01, c[9:7]};
		imm_ci   = {{6{c[12]}}, c[12], c[6:2]};
		imm_lui  = {{14{c[12]}}, c[12], c[6:2]};
		imm_cl   = {5'b00000, c[5], c[12:10], c[6], 2'b00};
		imm_cj   = {{9{c[12]}}, c[12], c[8], c[10:9], c[6], c[7], c[2], c[11], c[5:3], 1'b0};
		imm_cb   = {{4{c[12]}}, c[12], c[6:5], c[2], c[11:10], c[4:3], 1'b0};
		imm_sp16 = {c[12], c[4:3], c[5], c[2], c[6], 4'b0000};
		word     = '0;
		ok       = 1'b0;
		case (c[1:0])
			QUAD_C0: begin
				// the all-zero halfword stays illegal
				if (c != '0) begin
					case (c[15:13])
						C0_ADDI4SPN: begin
							word = enc_i(OPC_OPIMM, F3_ADD, rd_lo, REG_SP,
								{2'b00, c[10:7], c[12:11], c[6], c[5], 2'b00});
							ok = 1'b1;
						end
						C0_LW: begin
							word = enc_i(OPC_LOAD, F3_W, rd_lo, rd_hi, imm_cl);
							ok = 1'b1;
						end
						C0_SW: begin
							word = enc_s(F3_W, rd_hi, rd_lo, imm_cl);
							ok = 1'b1;
						end
						default: ;
					endcase
				end
			end
			QUAD_C1: begin
				case (c[15:13])
					C1_ADDI: begin
						word = enc_i(OPC_OPIMM, F3_ADD, rd_full, rd_full, imm_ci);
						ok = 1'b1;
					end
					C1_JAL: begin
						word = enc_j(REG_RA, imm_cj);
						ok = 1'b1;
					end
					C1_LI: begin
						word = enc_i(OPC_OPIMM, F3_ADD, rd_full, REG_ZERO, imm_ci);
						ok = 1'b1;
					end
					C1_LUI: begin
						if (rd_full == REG_SP) begin
							if (imm_sp16 != '0) begin
								word = enc_i(OPC_OPIMM, F3_ADD, REG_SP, REG_SP,
									{{2{c[12]}}, imm_sp16});
								ok = 1'b1;
							end
						end else if (rd_full != REG_ZERO && imm_ci != '0) begin
							word = {imm_lui, rd_full, OPC_LUI};
							ok = 1'b1;
						end
					end
					C1_ARITH: begin
						case (c[11:10])
							AR_SRLI: begin
								word = enc_r(OPC_OPIMM, F3_SR, rd_hi, rd_hi, rs2_full, F7_BASE);
								ok = 1'b1;
							end
							AR_SRAI: begin
								word = enc_r(OPC_OPIMM, F3_SR, rd_hi, rd_hi, rs2_full, F7_ALT);
								ok = 1'b1;
							end
							AR_ANDI: begin
								word = enc_i(OPC_OPIMM, F3_AND, rd_hi, rd_hi, imm_ci);
								ok = 1'b1;
							end
							default: begin
								// bit 12 set selects rv64 or reserved slots
								if (!c[12]) begin
									ok = 1'b1;
									case (c[6:5])
										RR_SUB: word = enc_r(OPC_OP, F3_ADD, rd_hi, rd_hi, rd_lo,
											F7_ALT);
										RR_XOR: word = enc_r(OPC_OP, F3_XOR, rd_hi, rd_hi, rd_lo,
											F7_BASE);
										RR_OR:  word = enc_r(OPC_OP, F3_OR, rd_hi, rd_hi, rd_lo,
											F7_BASE);
										default: word = enc_r(OPC_OP, F3_AND, rd_hi, rd_hi, rd_lo,
											F7_BASE);
									endcase
								end
							end
						endcase
					end
					C1_J: begin
						word = enc_j(REG_ZERO, imm_cj);
						ok = 1'b1;
					end
					C1_BEQZ: begin
						word = enc_b(F3_BEQ, rd_hi, imm_cb);
						ok = 1'b1;
					end
					default: begin
						word = enc_b(F3_BNE, rd_hi, imm_cb);
						ok = 1'b1;
					end
				endcase
			end
			QUAD_C2: begin
				case (c[15:13])
					C2_SLLI: begin
						word = enc_r(OPC_OPIMM, F3_SLL, rd_full, rd_full, rs2_full, F7_BASE);
						ok = 1'b1;
					end
					C2_LWSP: begin
						if (rd_full != REG_ZERO) begin
							word = enc_i(OPC_LOAD, F3_W, rd_full, REG_SP,
								{4'b0000, c[3:2], c[12], c[6:4], 2'b00});
							ok = 1'b1;
						end
					end
					C2_JR: begin
						if (!c[12]) begin
							if (rs2_full == REG_ZERO) begin
								if (rd_full != REG_ZERO) begin
									word = enc_i(OPC_JALR, F3_ADD, REG_ZERO, rd_full, 12'h000);
									ok = 1'b1;
								end
							end else begin
								word = enc_r(OPC_OP, F3_ADD, rd_full, REG_ZERO, rs2_full, F7_BASE);
								ok = 1'b1;
							end
						end else if (rd_full != REG_ZERO) begin
							if (rs2_full == REG_ZERO)
								word = enc_i(OPC_JALR, F3_ADD, REG_RA, rd_full, 12'h000);
							else
								word = enc_r(OPC_OP, F3_ADD, rd_full, rd_full, rs2_full, F7_BASE);
							ok = 1'b1;
						end
					end
					C2_SWSP: begin
						word = enc_s(F3_W, REG_SP, rs2_full, {4'b0000, c[8:7], c[12:9], 2'b00});
						ok = 1'b1;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		r.word = ok ? word : '0;
		r.ill  = !ok;
		return r;
	endfunction

	always @(posedge clk) begin : watch
		expansion_t head;
		int         errs;
		if (!arst_n) begin
			failures        <= 0;
			pending         <= 0;
			results         <= 0;
			illegal_results <= 0;
		end else begin
			errs = 0;
			if (fetch_valid && fetch_ready)
				expected_expansions.push_back(expand_halfword(compressed_word));
			if (issue_valid && issue_ready) begin
				results <= results + 1;
				if (illegal)
					illegal_results <= illegal_results + 1;
				if (expected_expansions.size() == 0) begin
					$error("unexpected request on issue: expanded_word %h illegal %b",
						expanded_word, illegal);
					errs = 1;
				end else begin
					head = expected_expansions.pop_front();
					if (expanded_word !== head.word) begin
						$error("expanded_word: expected %h, actual %h", head.word, expanded_word);
						errs = 1;
					end
					if (illegal !== head.ill) begin
						$error("illegal: expected %b, actual %b", head.ill, illegal);
						errs = 1;
					end
				end
			end
			failures <= failures + errs;
			pending  <= expected_expansions.size();
		end
	end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives compressed halfwords into the expander with random idle gaps and
// random issue back-pressure, one long hold-off included; the checker beside
// the block predicts every expansion and counts mismatches for the verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import cexp_pkg::*;

	localparam int RANDOM_ITEMS = 850;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES  = 300;
	localparam int HOLD_AFTER   = 250;

	logic clk;
	logic arst_n;

	cexp_in_if  fetch ();
	cexp_out_if issue ();

	int failures;
	int pending;
	int results;
	int illegal_results;
	int n_sent;
	int cycles;
	bit steady;
	bit held_off;

	// directed halfwords: extremes, every form and the odd corners
	logic [CWORD_W-1:0] directed_words [$] = '{
		16'h0000, // all-zero word
		16'hFFFF, // quadrant 3, not compressed
		16'h0004, // addi4spn with zero immediate, not flagged
		16'h1FFC, // addi4spn, largest immediate
		16'h5FFC, // lw
		16'hDFFC, // sw
		16'h2000, // floating-point load slot
		16'h1FFD, // addi x31, -1
		16'h3FFD, // jal
		16'h5FFD, // li
		16'h6101, // addi16sp with zero immediate
		16'h717D, // addi16sp, negative
		16'h6005, // lui to x0
		16'h6085, // lui x1
		16'h9001, // srli with bit 12 set
		16'h847D, // srai
		16'h9BFD, // andi
		16'h8C01, // sub
		16'h8C21, // xor
		16'h8C41, // or
		16'h8FFD, // and
		16'h9C01, // register group with bit 12 set
		16'hBFFD, // j
		16'hDFFD, // beqz
		16'hFFFD, // bnez
		16'h1FFE, // slli
		16'h4002, // lwsp to x0
		16'h5FFE, // lwsp
		16'h8002, // jr x0
		16'h8082, // jr
		16'h8FFE, // mv
		16'h9002, // ebreak
		16'h9082, // jalr
		16'h9FFE, // add
		16'hFFFE  // swsp
	};

	rvc_instruction_expander_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.fetch  (fetch),
		.issue  (issue)
	);

	rvc_expansion_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.fetch_valid     (fetch.valid),
		.fetch_ready     (fetch.ready),
		.compressed_word (fetch.compressed_word),
		.issue_valid     (issue.valid),
		.issue_ready     (issue.ready),
		.expanded_word   (issue.expanded_word),
		.illegal         (issue.illegal),
		.failures        (failures),
		.pending         (pending),
		.results         (results),
		.illegal_results (illegal_results)
	);

	// 8 ns clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog, bounds the whole run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[rvc_instruction_expander_top] ERROR");
			$finish;
		end
	end

	// idle length: mostly short, now and then long
	function automatic int idle_length();
		if ($urandom_range(0, 99) < 88)
			return $urandom_range(1, 3);
		return $urandom_range(15, 40);
	endfunction

	// random halfword: mostly quadrants 0..2, fields nudged toward the
	// zero-register and zero-immediate corners, a little quadrant 3 noise
	function automatic logic [CWORD_W-1:0] random_halfword();
		logic [CWORD_W-1:0] w;
		w = CWORD_W'($urandom);
		if (w[1:0] == QUAD_NC && $urandom_range(0, 9) != 0)
			w[1:0] = 2'($urandom_range(0, 2));
		case ($urandom_range(0, 7))
			0: w[11:7] = REG_ZERO;
			1: w[6:2] = '0;
			2: begin
				w[12]  = 1'b0;
				w[6:2] = '0;
			end
			3: w[11:7] = REG_SP;
			default: ;
		endcase
		return w;
	endfunction

	// offer one request and hold it until the block takes it
	task automatic send_request(input logic [CWORD_W-1:0] w);
		int gap;
		fetch.valid           <= 1'b1;
		fetch.compressed_word <= w;
		do @(posedge clk); while (!fetch.ready);
		n_sent++;
		gap = (steady || $urandom_range(0, 1)) ? 0 : idle_length();
		if (gap > 0) begin
			// junk payload while idle, the block must not take it
			fetch.valid           <= 1'b0;
			fetch.compressed_word <= CWORD_W'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	// issue side: random stalls, plus one long hold-off once the run is
	// underway so the pipeline fills and pushes back on fetch
	initial begin : issue_side
		int stall_left;
		int hold;
		issue.ready = 1'b0;
		stall_left  = 0;
		held_off    = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!held_off && n_sent >= HOLD_AFTER) begin
				issue.ready <= 1'b0;
				hold = 0;
				while (hold < HOLD_CYCLES) begin
					@(posedge clk);
					hold++;
				end
				held_off = 1'b1;
			end else if (stall_left > 0) begin
				issue.ready <= 1'b0;
				stall_left--;
			end else if (!steady && $urandom_range(0, 3) == 0) begin
				issue.ready <= 1'b0;
				stall_left = idle_length() - 1;
			end else begin
				issue.ready <= 1'b1;
			end
		end
	end

	// fetch side and verdict
	initial begin
		fetch.valid           = 1'b0;
		fetch.compressed_word = '0;
		arst_n                = 1'b0;
		n_sent                = 0;
		steady                = 1'b0;
		cycles                = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_words[i])
			send_request(directed_words[i]);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// one stretch with no idling on either side
			steady = (i >= 500 && i < 600);
			send_request(random_halfword());
		end
		steady = 1'b0;
		fetch.valid <= 1'b0;

		// wait for every expected request to come back, then through a drain period
		// to catch anything stray
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d directed and %0d random halfwords with a %0d-cycle issue hold-off",
			directed_words.size(), RANDOM_ITEMS, HOLD_CYCLES);
		$display("checked %0d expansions, %0d of them flagged illegal", results, illegal_results);
		if (failures == 0 && pending == 0)
			$display("[rvc_instruction_expander_top] OK");
		else
			$display("[rvc_instruction_expander_top] ERROR");
		$finish;
	end

endmodule

// File: rvc_instruction_expander_top.f
rtl/core/cexp_pkg.sv
rtl/core/cexp_in_if.sv
rtl/core/cexp_out_if.sv
rtl/core/cexp_decode.sv
rtl/core/cexp_encode.sv
rtl/core/rvc_instruction_expander_top.sv
sim/rvc_expansion_checker.sv
sim/tb_top.sv
